@@ design/pitot_airspeed_conditioner_unit_defines.svh @@
// Assertion macros used by the checker in pacu_checker.sv.
`ifndef PITOT_AIRSPEED_CONDITIONER_UNIT_DEFINES_SVH
`define PITOT_AIRSPEED_CONDITIONER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define PACU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define PACU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/pacu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pacu_pkg;

    typedef logic        [7:0]  byte_t;
    typedef logic signed [23:0] pressure_q8_t;
    typedef logic        [15:0] airspeed_q8_t;
    typedef logic signed [16:0] temperature_q8_t;

    // Calibration
    localparam int CAL_SAMPLES_DEF = 100;
    localparam int CAL_CNT_W       = 7;
    localparam int CAL_SUM_W       = 21;

    // Pascal per count scale: K_NUM / K_DEN, times 256 for Q8
    localparam int K_NUM = 172369;
    localparam int K_DEN = 163830;

    // Pressure divider: remainder holds up to 127 * K_DEN, quotient 30 bits
    localparam int DIV_W     = 25;
    localparam int DIV_STEPS = 30;

    // Temperature: (raw * 102400 + 2047) / 4094 - 12800
    localparam int T_SCALE  = 102400;
    localparam int T_BIAS   = 2047;
    localparam int T_DIV    = 4094;
    localparam int T_OFFSET = 12800;
    localparam int T_STEPS  = 16;

    // Square root: largest k with 49 * k^2 <= y, two bits of y per step
    localparam int SQ_STEPS = 24;
    localparam int SQ_ODD   = 49;
    localparam int SQ_TWO   = 196;

endpackage

`default_nettype wire

@@ design/pitot_airspeed_conditioner_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Pitot airspeed conditioner.
// Input channel (s_valid / s_ready): one 4-byte sensor frame per word plus
// s_frame_ok, which flags a complete read. Result channel (m_valid / m_ready):
// one word per input word with zero-corrected pressure, airspeed and
// temperature in Q8, plus m_sample_valid and m_calibrating.
// After reset the first CAL_SAMPLES good frames are summed into the zero
// offset; those words, and every failed read, come out with zero fields and
// m_sample_valid low.
// A word that yields a sample goes from accept to m_valid through the
// setup states ST_CALC and ST_MUL, a 30-step bit-serial divider for the
// pressure scale, a rounding state, a 24-step two-bit-per-step square root
// and the output state ST_DONE. Other words go straight to ST_DONE. Each
// word reaches ST_DONE before the next one is accepted.
// The result sits in an output register: a stalled m_ready does not stop
// the next word from being accepted and worked on; the block only waits
// at the end of that word until the output register frees up.
// Reset (aresetn low, synchronous) clears the calibration count and sum and
// drops any word in flight.
module pitot_airspeed_conditioner_unit #(
    parameter int CAL_SAMPLES = pacu_pkg::CAL_SAMPLES_DEF
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        s_valid,
    output logic                       s_ready,
    input  wire pacu_pkg::byte_t       s_status_pressure_high,
    input  wire pacu_pkg::byte_t       s_pressure_low,
    input  wire pacu_pkg::byte_t       s_temperature_high,
    input  wire pacu_pkg::byte_t       s_temperature_low,
    input  wire                        s_frame_ok,
    output logic                       m_valid,
    input  wire                        m_ready,
    output pacu_pkg::pressure_q8_t     m_pressure_q8,
    output pacu_pkg::airspeed_q8_t     m_airspeed_q8,
    output pacu_pkg::temperature_q8_t  m_temperature_q8,
    output logic                       m_sample_valid,
    output logic                       m_calibrating
);
    import pacu_pkg::*;

    localparam logic [CAL_CNT_W-1:0] CAL_N = CAL_CNT_W'(CAL_SAMPLES);
    localparam logic [DIV_W-1:0]     DEN   = DIV_W'(CAL_SAMPLES * K_DEN);

    // Sequencer codes
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CALC  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_ROUND = 3'd4;
    localparam logic [2:0] ST_SQRT  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]             state_reg, state_next;
    logic [4:0]             cnt_reg, cnt_next;
    logic [CAL_CNT_W-1:0]   cal_count_reg, cal_count_next;
    logic [CAL_SUM_W-1:0]   cal_sum_reg, cal_sum_next;
    logic                   item_valid_reg, item_valid_next;
    logic                   item_cal_reg, item_cal_next;
    logic [13:0]            rawp_reg, rawp_next;
    logic [10:0]            rawt_reg, rawt_next;
    logic                   neg_reg, neg_next;
    logic [21:0]            mag_reg, mag_next;
    logic [27:0]            tnum_reg, tnum_next;
    logic [DIV_W-1:0]       drem_reg, drem_next;
    logic [29:0]            dquo_reg, dquo_next;
    logic [11:0]            trem_reg, trem_next;
    logic [15:0]            tquo_reg, tquo_next;
    logic [47:0]            y_reg, y_next;
    logic [27:0]            srem_reg, srem_next;
    logic [28:0]            st_reg, st_next;
    logic [20:0]            root_reg, root_next;
    pressure_q8_t           p_res_reg, p_res_next;
    airspeed_q8_t           v_res_reg, v_res_next;
    temperature_q8_t        t_res_reg, t_res_next;
    logic                   m_valid_reg, m_valid_next;
    pressure_q8_t           m_p_reg, m_p_next;
    airspeed_q8_t           m_v_reg, m_v_next;
    temperature_q8_t        m_t_reg, m_t_next;
    logic                   m_sv_reg, m_sv_next;
    logic                   m_cal_reg, m_cal_next;

    // Datapath pieces
    logic                   in_cal;
    logic [22:0]            diff;
    logic [39:0]            num_prod;
    logic [DIV_W:0]         dsh;
    logic                   dge;
    logic [DIV_W-1:0]       drem_step;
    logic [12:0]            tsh;
    logic                   tge;
    logic [11:0]            trem_step;
    logic                   round_up;
    logic [30:0]            q_round;
    logic [29:0]            ssh;
    logic [29:0]            strial;
    logic                   sge;
    logic [27:0]            srem_step;
    logic [20:0]            root_step;
    logic [28:0]            st_step;
    logic [21:0]            root_inc;

    // Calibration still open while the count is short of CAL_SAMPLES
    assign in_cal = cal_count_reg < CAL_N;

    // raw * N - sum, as a signed 23-bit value
    assign diff = {2'b00, 21'(rawp_reg) * 21'(CAL_N)} - {2'b00, cal_sum_reg};

    assign num_prod = 40'(mag_reg) * 40'(K_NUM);

    // Restoring divide step, pressure: one quotient bit per cycle
    assign dsh       = {drem_reg, dquo_reg[29]};
    assign dge       = dsh >= {1'b0, DEN};
    assign drem_step = dge ? DIV_W'(dsh - {1'b0, DEN}) : dsh[DIV_W-1:0];

    // Restoring divide step, temperature
    assign tsh       = {trem_reg, tquo_reg[15]};
    assign tge       = tsh >= 13'(T_DIV);
    assign trem_step = tge ? 12'(tsh - 13'(T_DIV)) : tsh[11:0];

    // Round half up: add one when twice the remainder reaches the divisor
    assign round_up = {drem_reg, 1'b0} >= {1'b0, DEN};
    assign q_round  = {1'b0, dquo_reg} + 31'(round_up);

    // Square root step; st_reg tracks 196 * root, trial is 49 * (4 * root + 1)
    assign ssh       = {srem_reg, y_reg[47:46]};
    assign strial    = {1'b0, st_reg} + 30'(SQ_ODD);
    assign sge       = ssh >= strial;
    assign srem_step = sge ? 28'(ssh - strial) : ssh[27:0];
    assign root_step = {root_reg[19:0], sge};
    assign st_step   = 29'({st_reg, 1'b0} + (sge ? 30'(SQ_TWO) : 30'd0));
    assign root_inc  = {1'b0, root_step} + 22'd1;

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        cal_count_next  = cal_count_reg;
        cal_sum_next    = cal_sum_reg;
        item_valid_next = item_valid_reg;
        item_cal_next   = item_cal_reg;
        rawp_next       = rawp_reg;
        rawt_next       = rawt_reg;
        neg_next        = neg_reg;
        mag_next        = mag_reg;
        tnum_next       = tnum_reg;
        drem_next       = drem_reg;
        dquo_next       = dquo_reg;
        trem_next       = trem_reg;
        tquo_next       = tquo_reg;
        y_next          = y_reg;
        srem_next       = srem_reg;
        st_next         = st_reg;
        root_next       = root_reg;
        p_res_next      = p_res_reg;
        v_res_next      = v_res_reg;
        t_res_next      = t_res_reg;
        m_p_next        = m_p_reg;
        m_v_next        = m_v_reg;
        m_t_next        = m_t_reg;
        m_sv_next       = m_sv_reg;
        m_cal_next      = m_cal_reg;
        // Drop the output word once taken
        m_valid_next    = m_valid_reg && !m_ready;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    rawp_next       = {s_status_pressure_high[5:0], s_pressure_low};
                    rawt_next       = {s_temperature_high, s_temperature_low[7:5]};
                    item_cal_next   = in_cal;
                    item_valid_next = s_frame_ok && !in_cal;
                    p_res_next      = '0;
                    v_res_next      = '0;
                    t_res_next      = '0;
                    // Fold a good frame into the offset while calibrating
                    if (s_frame_ok && in_cal) begin
                        cal_sum_next   = cal_sum_reg + CAL_SUM_W'({s_status_pressure_high[5:0],
                                                                   s_pressure_low});
                        cal_count_next = cal_count_reg + CAL_CNT_W'(1);
                    end
                    state_next = (s_frame_ok && !in_cal) ? ST_CALC : ST_DONE;
                end
            end
            ST_CALC: begin
                neg_next   = diff[22];
                mag_next   = diff[22] ? 22'(-diff) : diff[21:0];
                tnum_next  = 28'(rawt_reg) * 28'(T_SCALE) + 28'(T_BIAS);
                state_next = ST_MUL;
            end
            ST_MUL: begin
                // Dividend is num_prod * 256; the top 18 bits stay below the divisor
                drem_next  = DIV_W'(num_prod[39:22]);
                dquo_next  = {num_prod[21:0], 8'd0};
                trem_next  = tnum_reg[27:16];
                tquo_next  = tnum_reg[15:0];
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                drem_next = drem_step;
                dquo_next = {dquo_reg[28:0], dge};
                if (cnt_reg < 5'(T_STEPS)) begin
                    trem_next = trem_step;
                    tquo_next = {tquo_reg[14:0], tge};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1)) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                p_res_next = neg_reg ? 24'(-q_round) : q_round[23:0];
                t_res_next = 17'({1'b0, tquo_reg} - 17'(T_OFFSET));
                // y = q * 81920 = q * (2^16 + 2^14)
                y_next     = (48'(q_round) << 16) + (48'(q_round) << 14);
                srem_next  = '0;
                st_next    = '0;
                root_next  = '0;
                cnt_next   = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                y_next    = {y_reg[45:0], 2'b00};
                srem_next = srem_step;
                st_next   = st_step;
                root_next = root_step;
                cnt_next  = cnt_reg + 5'd1;
                if (cnt_reg == 5'(SQ_STEPS - 1)) begin
                    // airspeed = (k + 1) / 2, saturated to 16 bits
                    v_res_next = (|root_inc[21:17]) ? 16'hFFFF : root_inc[16:1];
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_p_next     = p_res_reg;
                    m_v_next     = v_res_reg;
                    m_t_next     = t_res_reg;
                    m_sv_next    = item_valid_reg;
                    m_cal_next   = item_cal_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            cal_count_reg <= '0;
            cal_sum_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cal_count_reg <= cal_count_next;
            cal_sum_reg   <= cal_sum_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_valid_reg <= item_valid_next;
        item_cal_reg   <= item_cal_next;
        rawp_reg       <= rawp_next;
        rawt_reg       <= rawt_next;
        neg_reg        <= neg_next;
        mag_reg        <= mag_next;
        tnum_reg       <= tnum_next;
        drem_reg       <= drem_next;
        dquo_reg       <= dquo_next;
        trem_reg       <= trem_next;
        tquo_reg       <= tquo_next;
        y_reg          <= y_next;
        srem_reg       <= srem_next;
        st_reg         <= st_next;
        root_reg       <= root_next;
        p_res_reg      <= p_res_next;
        v_res_reg      <= v_res_next;
        t_res_reg      <= t_res_next;
        m_p_reg        <= m_p_next;
        m_v_reg        <= m_v_next;
        m_t_reg        <= m_t_next;
        m_sv_reg       <= m_sv_next;
        m_cal_reg      <= m_cal_next;
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_pressure_q8    = m_p_reg;
    assign m_airspeed_q8    = m_v_reg;
    assign m_temperature_q8 = m_t_reg;
    assign m_sample_valid   = m_sv_reg;
    assign m_calibrating    = m_cal_reg;

endmodule

`default_nettype wire

@@ design/pacu_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "pitot_airspeed_conditioner_unit_defines.svh"

module pacu_checker (
    input wire                        aclk,
    input wire                        aresetn,
    input wire                        s_valid,
    input wire                        s_ready,
    input wire pacu_pkg::byte_t       s_status_pressure_high,
    input wire pacu_pkg::byte_t       s_pressure_low,
    input wire pacu_pkg::byte_t       s_temperature_high,
    input wire pacu_pkg::byte_t       s_temperature_low,
    input wire                        s_frame_ok,
    input wire                        m_valid,
    input wire                        m_ready,
    input wire pacu_pkg::pressure_q8_t    m_pressure_q8,
    input wire pacu_pkg::airspeed_q8_t    m_airspeed_q8,
    input wire pacu_pkg::temperature_q8_t m_temperature_q8,
    input wire                        m_sample_valid,
    input wire                        m_calibrating
);
    import pacu_pkg::*;

    // Waiting input word holds
    `PACU_ASSERT_NEXT(a_in_hold, s_valid && !s_ready,
        s_valid && $stable(s_status_pressure_high) && $stable(s_pressure_low)
        && $stable(s_temperature_high) && $stable(s_temperature_low) && $stable(s_frame_ok), "input word changed while waiting")

    // Stalled output word holds
    `PACU_ASSERT_NEXT(a_out_hold, m_valid && !m_ready,
        m_valid && $stable(m_pressure_q8) && $stable(m_airspeed_q8)
        && $stable(m_temperature_q8) && $stable(m_sample_valid), "output word changed while stalled")

    // A calibration word never carries a sample
    `PACU_ASSERT_SAME(a_cal_excl, m_valid && m_calibrating, !m_sample_valid,
        "sample flagged valid during calibration")

    // Words without a sample carry zero fields
    `PACU_ASSERT_SAME(a_zero_fields, m_valid && !m_sample_valid,
        m_pressure_q8 == '0 && m_airspeed_q8 == '0 && m_temperature_q8 == '0,
        "nonzero fields on a word without a sample")

    // Temperature stays within the sensor span
    `PACU_ASSERT_SAME(a_temp_range, m_valid,
        m_temperature_q8 >= -17'sd12800 && m_temperature_q8 <= 17'sd38400,
        "temperature out of range")

endmodule

bind pitot_airspeed_conditioner_unit pacu_checker u_pacu_checker (.*);

`default_nettype wire
